// ----- rtl/edtm_pkg.sv -----
// Shared types and constants for the echo distance to tone mapper.
// Holds the controller state type, register index codes and the pitch table.
// No dependencies.
`timescale 1ns / 1ps

package edtm_pkg;

   // Field widths fixed by the interface
   localparam int ECHO_W      = 15;
   localparam int KNOB_W      = 12;
   localparam int TIME_W      = 32;
   localparam int TONE_W      = 12;
   localparam int NOTE_W      = 4;
   localparam int OCT_W       = 3;
   localparam int TENTHS_W    = 13;
   localparam int DEBOUNCE_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Datapath widths
   localparam int READ_W      = 19;   // one stored reading, 0.001 cm
   localparam int DIVISOR_W   = 13;   // count*100 or note span
   localparam int SCALED_W    = 20;   // a 13-bit limit times 100
   localparam int PITCH_W     = 16;
   localparam int TONE_X_W    = 19;   // pitch shifted up by at most three octaves
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 22;
   localparam int PROD_W      = TONE_X_W - 2 + RECIP_W;

   // Register index codes
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DIST = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DIST = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 2'd2;

   localparam logic [TENTHS_W-1:0]   MIN_DIST_RESET = 13'd30;
   localparam logic [TENTHS_W-1:0]   MAX_DIST_RESET = 13'd400;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd200;

   localparam logic [READ_W-1:0] READING_MAX = 19'h7FFFF;
   localparam logic [4:0]        ECHO_SCALE  = 5'd17;     // us to 0.001 cm
   localparam logic [6:0]        CENTI       = 7'd100;
   localparam int                KNOB_FULL   = 4095;
   localparam int                KNOB_STEPS  = 5;

   localparam logic [NOTE_W-1:0] NOTE_TOP  = 4'd11;
   localparam logic [NOTE_W-1:0] NOTE_NONE = 4'd15;
   localparam logic [OCT_W-1:0]  OCT_NONE  = 3'd0;
   localparam logic [OCT_W-1:0]  OCT_BASE  = 3'd2;
   localparam logic [OCT_W-1:0]  OCT_REF   = 3'd4;

   // ceil(2^22 / 25); exact floor(y/25) for y below 2^22/21
   localparam logic [RECIP_W-1:0] RECIP_25 = 18'd167773;

   // Octave-4 pitches in hundredths of a hertz, C through B
   localparam logic [PITCH_W-1:0] PITCH_CENTI_HZ [12] = '{
      16'd26163, 16'd27718, 16'd29366, 16'd31113, 16'd32963, 16'd34923,
      16'd36999, 16'd39200, 16'd41530, 16'd44000, 16'd46616, 16'd49388
   };

   typedef enum logic [3:0] {
      S_IDLE,
      S_WRITE,
      S_SUM,
      S_LOAD,
      S_DIV_AVG,
      S_RANGE,
      S_NOTE,
      S_DIV_NOTE,
      S_PICK,
      S_CHECK,
      S_RECIP,
      S_TONE,
      S_FINISH
   } state_type;

endpackage

// ----- rtl/echo_distance_to_tone_mapper_unit.sv -----
// Echo distance to tone mapper: reading ring memory, averaging and note/tone control.
// Depends on edtm_pkg.
`timescale 1ns / 1ps

// One transfer in gives one transfer out. After the input transfer of an item,
// input ready stays low until its result is loaded into the output register,
// so it also stays low while a finished result waits for a full output register.
// For an item with an echo reading the wait is set by the one-bit-per-cycle
// restoring divider, shared by the ring average and the note mapping, and by
// the sweep that reads the ring memory one entry per cycle. A finished result
// waits in the output register while the next item is taken.
// The ring memory holds RING_DEPTH readings with a valid bit per entry, so it
// is empty right after reset with no clearing pass. Registers: 0 near limit,
// 1 far limit (tenths of cm), 2 debounce window (ms); write them only while
// the block is idle.
module echo_distance_to_tone_mapper_unit
   import edtm_pkg::*;
#(
   parameter int RING_DEPTH = 5
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ECHO_W-1:0]      req_echo_width_us,
   input  logic [KNOB_W-1:0]      req_knob_sample,
   input  logic                   req_button_pressed,
   input  logic [TIME_W-1:0]      req_time_ms,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [TONE_W-1:0]      rsp_tone_hz,
   output logic                   rsp_tone_write,
   output logic [NOTE_W-1:0]      rsp_note_index,
   output logic [OCT_W-1:0]       rsp_octave_number,
   output logic [TENTHS_W-1:0]    rsp_distance_tenths,
   output logic                   rsp_distance_valid,
   output logic                   rsp_muted_flag,
   output logic                   rsp_in_range,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int SUM_W  = READ_W + CNT_W;
   localparam int LIM_W  = SCALED_W + CNT_W;
   localparam int DCNT_W = $clog2(SUM_W);
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(RING_DEPTH - 1);

   // Controller
   state_type state_ff, state_in;

   // Configuration
   logic [TENTHS_W-1:0]   min_dist_ff, max_dist_ff;
   logic [DEBOUNCE_W-1:0] debounce_ff;

   // Persistent state
   logic [RING_DEPTH-1:0] entry_vld_ff;
   logic [ADDR_W-1:0]     slot_ff;
   logic                  mute_ff;
   logic [TIME_W-1:0]     last_press_ff;
   logic [NOTE_W-1:0]     last_note_ff;
   logic [OCT_W-1:0]      last_oct_ff;
   logic [TONE_W-1:0]     held_tone_ff;

   // Ring memory
   logic [READ_W-1:0]     ring_mem [RING_DEPTH];
   logic [READ_W-1:0]     rd_data_ff;
   logic                  rd_ok_ff;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  mem_we, rd_en;

   // Per-item working registers
   logic [READ_W-1:0]     reading_ff;
   logic [OCT_W-1:0]      oct_ff;
   logic                  valid_ff, play_ff, write_ff;
   logic [NOTE_W-1:0]     note_ff;
   logic [CNT_W-1:0]      idx_ff, cnt_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [SCALED_W-1:0]   min100_ff, max100_ff;
   logic [LIM_W-1:0]      lo_ff, hi_ff;
   logic [TENTHS_W-1:0]   tenths_ff;
   logic [TONE_X_W-1:0]   tone_x_ff;
   logic [PROD_W-1:0]     prod_ff;

   // Shared restoring divider
   logic [DIVISOR_W-1:0]  div_rem_ff, div_dvs_ff;
   logic [SUM_W-1:0]      div_quo_ff;
   logic [DCNT_W-1:0]     div_cnt_ff;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W+1:0]  trial;
   logic                  fits, div_last, div_step;

   // Output register
   logic                  rsp_valid_ff;
   logic [TONE_W-1:0]     rsp_tone_ff;
   logic                  rsp_write_ff;
   logic [NOTE_W-1:0]     rsp_note_ff;
   logic [OCT_W-1:0]      rsp_oct_ff;
   logic [TENTHS_W-1:0]   rsp_tenths_ff;
   logic                  rsp_dvalid_ff, rsp_muted_ff, rsp_range_ff;

   // Combinational helpers
   logic                  req_xfer, rsp_load;
   logic                  press_ok;
   logic [TIME_W-1:0]     elapsed;
   logic [19:0]           echo_x17;
   logic [READ_W-1:0]     reading_in;
   logic [14:0]           knob_x5;
   logic [OCT_W-1:0]      oct_in;
   logic                  last_idx, play_now, tone_change;
   logic [TENTHS_W-1:0]   span, off;
   logic [TONE_X_W-1:0]   tone_x_in;
   logic [PITCH_W-1:0]    pitch;
   logic [PROD_W-RECIP_SHIFT-1:0] tone_q;
   logic [TONE_W-1:0]     tone_in;

   // Handshake and press debounce
   assign req_xfer = req_valid && req_ready;
   assign rsp_load = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign elapsed  = req_time_ms - last_press_ff;
   assign press_ok = req_button_pressed && (elapsed > TIME_W'(debounce_ff));

   // Echo width to saturated reading
   assign echo_x17   = 20'(req_echo_width_us) * 20'(ECHO_SCALE);
   assign reading_in = echo_x17[19] ? READING_MAX : echo_x17[READ_W-1:0];

   // Knob to octave: count thresholds k*4095 reached by knob*5
   assign knob_x5 = 15'(req_knob_sample) * 15'(KNOB_STEPS);
   always_comb begin
      oct_in = OCT_BASE;
      for (int k = 1; k <= KNOB_STEPS; k++) begin
         if (knob_x5 >= 15'(k * KNOB_FULL)) oct_in = oct_in + 3'd1;
      end
   end

   // Divider step
   assign rem_shift = {div_rem_ff, div_quo_ff[SUM_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, div_dvs_ff};
   assign fits      = !trial[DIVISOR_W+1];
   assign div_last  = (div_cnt_ff == DCNT_W'(SUM_W - 1));

   // Range test, note offset and tone-change test
   assign last_idx    = (idx_ff == CNT_W'(RING_DEPTH));
   assign play_now    = !mute_ff && (LIM_W'(sum_ff) >= lo_ff) && (LIM_W'(sum_ff) <= hi_ff);
   assign span        = max_dist_ff - min_dist_ff;
   assign off         = (tenths_ff >= min_dist_ff) ? tenths_ff - min_dist_ff : '0;
   assign tone_change = (note_ff != last_note_ff) || (oct_ff != last_oct_ff);

   // Tone: pitch scaled by octave, divided by 100 through a reciprocal
   assign pitch     = PITCH_CENTI_HZ[note_ff];
   assign tone_x_in = (oct_ff >= OCT_REF) ? (TONE_X_W'(pitch) << (oct_ff - OCT_REF))
                                          : TONE_X_W'(pitch);
   assign tone_q    = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign tone_in   = (oct_ff >= OCT_REF) ? TONE_W'(tone_q)
                                          : TONE_W'(tone_q >> (OCT_REF - oct_ff));

   assign rd_addr = idx_ff[ADDR_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) state_in = (req_echo_width_us != '0) ? S_WRITE : S_FINISH;
         end
         S_WRITE:    state_in = S_SUM;
         S_SUM: begin
            if (last_idx) state_in = S_LOAD;
         end
         S_LOAD:     state_in = S_DIV_AVG;
         S_DIV_AVG: begin
            if (div_last) state_in = S_RANGE;
         end
         S_RANGE:    state_in = play_now ? S_NOTE : S_FINISH;
         S_NOTE:     state_in = (span == '0) ? S_CHECK : S_DIV_NOTE;
         S_DIV_NOTE: begin
            if (div_last) state_in = S_PICK;
         end
         S_PICK:     state_in = S_CHECK;
         S_CHECK:    state_in = tone_change ? S_RECIP : S_FINISH;
         S_RECIP:    state_in = S_TONE;
         S_TONE:     state_in = S_FINISH;
         S_FINISH: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // Controller outputs
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      rd_en     = 1'b0;
      div_step  = 1'b0;
      case (state_ff)
         S_IDLE:     req_ready = 1'b1;
         S_WRITE:    mem_we    = 1'b1;
         S_SUM:      rd_en     = !last_idx;
         S_DIV_AVG:  div_step  = 1'b1;
         S_DIV_NOTE: div_step  = 1'b1;
         default: begin
         end
      endcase
   end

   // Ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[slot_ff] <= reading_ff;
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
         rd_ok_ff   <= entry_vld_ff[rd_addr];
      end
   end

   // Control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         min_dist_ff   <= MIN_DIST_RESET;
         max_dist_ff   <= MAX_DIST_RESET;
         debounce_ff   <= DEBOUNCE_RESET;
         entry_vld_ff  <= '0;
         slot_ff       <= '0;
         mute_ff       <= 1'b0;
         last_press_ff <= '0;
         last_note_ff  <= NOTE_NONE;
         last_oct_ff   <= OCT_NONE;
         held_tone_ff  <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MIN_DIST) min_dist_ff <= csr_data[TENTHS_W-1:0];
            if (csr_index == CSR_MAX_DIST) max_dist_ff <= csr_data[TENTHS_W-1:0];
            if (csr_index == CSR_DEBOUNCE) debounce_ff <= csr_data;
         end

         if (req_xfer && press_ok) begin
            mute_ff       <= !mute_ff;
            last_press_ff <= req_time_ms;
         end

         if (mem_we) begin
            entry_vld_ff[slot_ff] <= 1'b1;
            slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         end

         // note/octave bookkeeping for playing and silent items
         if (state_ff == S_CHECK && tone_change) begin
            last_note_ff <= note_ff;
            last_oct_ff  <= oct_ff;
         end
         if (state_ff == S_FINISH && !play_ff) begin
            last_note_ff <= NOTE_NONE;
            last_oct_ff  <= OCT_NONE;
         end
         if (state_ff == S_TONE) held_tone_ff <= tone_in;

         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Per-item datapath and divider
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            reading_ff <= reading_in;
            oct_ff     <= oct_in;
            valid_ff   <= (req_echo_width_us != '0);
            play_ff    <= 1'b0;
            write_ff   <= 1'b1;
            note_ff    <= '0;
            tenths_ff  <= '0;
         end
         S_WRITE: begin
            idx_ff <= '0;
            cnt_ff <= '0;
            sum_ff <= '0;
         end
         S_SUM: begin
            idx_ff <= idx_ff + 1'b1;
            if (idx_ff != '0 && rd_ok_ff && rd_data_ff != '0) begin
               sum_ff <= sum_ff + SUM_W'(rd_data_ff);
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         S_LOAD: begin
            div_rem_ff <= '0;
            div_quo_ff <= sum_ff;
            div_dvs_ff <= DIVISOR_W'(cnt_ff) * DIVISOR_W'(CENTI);
            div_cnt_ff <= '0;
            min100_ff  <= SCALED_W'(min_dist_ff) * SCALED_W'(CENTI);
            max100_ff  <= SCALED_W'(max_dist_ff) * SCALED_W'(CENTI);
         end
         S_DIV_AVG: begin
            lo_ff <= LIM_W'(min100_ff) * LIM_W'(cnt_ff);
            hi_ff <= LIM_W'(max100_ff) * LIM_W'(cnt_ff);
         end
         S_RANGE: begin
            tenths_ff <= div_quo_ff[TENTHS_W-1:0];
            play_ff   <= play_now;
         end
         S_NOTE: begin
            if (span == '0) note_ff <= NOTE_TOP;
            div_rem_ff <= '0;
            div_quo_ff <= SUM_W'(off) * SUM_W'(NOTE_TOP);
            div_dvs_ff <= span;
            div_cnt_ff <= '0;
         end
         S_PICK: begin
            note_ff <= (div_quo_ff >= SUM_W'(NOTE_TOP)) ? '0
                                                        : NOTE_TOP - div_quo_ff[NOTE_W-1:0];
         end
         S_CHECK: begin
            write_ff  <= tone_change;
            tone_x_ff <= tone_x_in;
         end
         S_RECIP: begin
            prod_ff <= PROD_W'(tone_x_ff[TONE_X_W-1:2]) * PROD_W'(RECIP_25);
         end
         default: begin
         end
      endcase

      // one quotient bit per cycle
      if (div_step) begin
         div_rem_ff <= fits ? trial[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         div_quo_ff <= {div_quo_ff[SUM_W-2:0], fits};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end

      if (rsp_load) begin
         rsp_tone_ff   <= play_ff ? held_tone_ff : '0;
         rsp_write_ff  <= write_ff;
         rsp_note_ff   <= play_ff ? note_ff : '0;
         rsp_oct_ff    <= oct_ff;
         rsp_tenths_ff <= valid_ff ? tenths_ff : '0;
         rsp_dvalid_ff <= valid_ff;
         rsp_muted_ff  <= mute_ff;
         rsp_range_ff  <= play_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tone_hz         = rsp_tone_ff;
   assign rsp_tone_write      = rsp_write_ff;
   assign rsp_note_index      = rsp_note_ff;
   assign rsp_octave_number   = rsp_oct_ff;
   assign rsp_distance_tenths = rsp_tenths_ff;
   assign rsp_distance_valid  = rsp_dvalid_ff;
   assign rsp_muted_flag      = rsp_muted_ff;
   assign rsp_in_range        = rsp_range_ff;

   // Checks
   a_ring_never_stores_empty: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (reading_ff != '0))
      else $error("zero reading written to ring");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_step |-> (div_dvs_ff != '0))
      else $error("divider running with zero divisor");

   a_play_needs_distance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_range) |-> (rsp_distance_valid && !rsp_muted_flag))
      else $error("note played without valid unmuted distance");

   a_silent_rewrites_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_range) |-> (rsp_tone_hz == '0 && rsp_tone_write
                                         && rsp_note_index == '0))
      else $error("silent result not silencing the generator");

   a_echo_goes_to_ring: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_echo_width_us != '0) |=> (state_ff == S_WRITE))
      else $error("echo reading not stored");

endmodule
